// ===== rtl/blpg_pkg.sv =====
package blpg_pkg;

    // port field width, fixed by the interface
    localparam int FIELD_BITS = 6;

    typedef logic [FIELD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } segment_t;

    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        logic   last_pixel;
    } pixel_t;

endpackage

// ===== rtl/bresenham_line_pixel_generator.sv =====
// Draws one line segment per start beat: every pixel that integer Bresenham
// visits from the start pixel up to, but not including, the end pixel, one
// pixel per clock on pixel/pixel_strobe, with last_pixel set on the final one.
// A segment of n = max(|dx|, |dy|) pixels keeps the walker for a load step,
// then one pixel a cycle. When the walker is free, a start beat is queued,
// popped into the walker, and its first pixel is then registered out. A
// two-entry queue sits between the input classifier and the
// walker, so busy rises only when two segments are waiting; a zero-length
// segment is taken and gives no pixel. Results cannot be held off: the
// receiver must take every strobe.
module bresenham_line_pixel_generator #(
    parameter int COORD_BITS = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  blpg_pkg::segment_t  segment,
    output blpg_pkg::pixel_t    pixel,
    output logic                pixel_strobe
);

    localparam int EntryBits = 6 * COORD_BITS + 2;

    logic                 push;
    logic                 pop;
    logic                 q_full;
    logic                 q_empty;
    logic [EntryBits-1:0] wr_entry;
    logic [EntryBits-1:0] rd_entry;

    // classify the beat: grid reduction, direction, span, zero-length drop
    blpg_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .start   (start),
        .full    (q_full),
        .segment (segment),
        .push    (push),
        .entry   (wr_entry)
    );

    // short queue decouples input beats from the walk
    blpg_queue #(
        .COORD_BITS(COORD_BITS)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .rd_entry (rd_entry),
        .full     (q_full),
        .empty    (q_empty)
    );

    // error-term walker, one pixel per cycle into a registered output
    blpg_walker #(
        .COORD_BITS(COORD_BITS)
    ) u_walker (
        .clk          (clk),
        .rst_n        (rst_n),
        .entry        (rd_entry),
        .empty        (q_empty),
        .pop          (pop),
        .pixel        (pixel),
        .pixel_strobe (pixel_strobe)
    );

    // stall input only while the queue is full
    assign busy = q_full;

`ifndef SYNTH
    // the walker reloads after a run, leaving a gap after every last pixel
    a_gap_after_last : assert property (@(posedge clk) disable iff (!rst_n)
        pixel_strobe && pixel.last_pixel |=> !pixel_strobe)
        else $error("strobe right after last pixel");

    // a run never breaks before its last pixel
    a_run_unbroken : assert property (@(posedge clk) disable iff (!rst_n)
        pixel_strobe && !pixel.last_pixel |=> pixel_strobe)
        else $error("run broken before last pixel");

    // nothing is queued while the queue reports full
    a_no_push_full : assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push)
        else $error("push into full queue");
`endif

endmodule

// ===== rtl/blpg_front.sv =====
module blpg_front #(
    parameter int COORD_BITS = 6
) (
    input  logic                     start,
    input  logic                     full,
    input  blpg_pkg::segment_t       segment,
    output logic                     push,
    output logic [6*COORD_BITS+1:0]  entry
);

    typedef struct packed {
        logic [COORD_BITS-1:0] x0;
        logic [COORD_BITS-1:0] y0;
        logic [COORD_BITS-1:0] x1;
        logic [COORD_BITS-1:0] y1;
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
        logic                  sx_up;
        logic                  sy_up;
    } entry_t;

    entry_t ent;
    logic   zero_len;

    // reduce onto the grid, then classify direction and span
    always_comb
    begin
        ent.x0    = segment.start_x[COORD_BITS-1:0];
        ent.y0    = segment.start_y[COORD_BITS-1:0];
        ent.x1    = segment.end_x[COORD_BITS-1:0];
        ent.y1    = segment.end_y[COORD_BITS-1:0];
        ent.sx_up = ent.x0 < ent.x1;
        ent.sy_up = ent.y0 < ent.y1;
        ent.dx    = ent.sx_up ? (ent.x1 - ent.x0) : (ent.x0 - ent.x1);
        ent.dy    = ent.sy_up ? (ent.y1 - ent.y0) : (ent.y0 - ent.y1);
        zero_len  = (ent.x0 == ent.x1) && (ent.y0 == ent.y1);
    end

    // zero-length segments are taken but never queued
    assign push  = start && !full && !zero_len;
    assign entry = ent;

endmodule

// ===== rtl/blpg_queue.sv =====
module blpg_queue #(
    parameter int COORD_BITS = 6
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  logic [6*COORD_BITS+1:0]  wr_entry,
    input  logic                     pop,
    output logic [6*COORD_BITS+1:0]  rd_entry,
    output logic                     full,
    output logic                     empty
);

    localparam int Depth = 2;

    logic [6*COORD_BITS+1:0] slot_reg [Depth];
    logic                    wr_ptr_reg;
    logic                    wr_ptr_next;
    logic                    rd_ptr_reg;
    logic                    rd_ptr_next;
    logic [1:0]              count_reg;
    logic [1:0]              count_next;

    assign full     = count_reg == 2'(Depth);
    assign empty    = count_reg == 2'd0;
    assign rd_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

// ===== rtl/blpg_walker.sv =====
module blpg_walker #(
    parameter int COORD_BITS = 6
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [6*COORD_BITS+1:0]  entry,
    input  logic                     empty,
    output logic                     pop,
    output blpg_pkg::pixel_t         pixel,
    output logic                     pixel_strobe
);

    localparam int ErrBits   = COORD_BITS + 2;
    localparam int TwiceBits = COORD_BITS + 3;

    typedef struct packed {
        logic [COORD_BITS-1:0] x0;
        logic [COORD_BITS-1:0] y0;
        logic [COORD_BITS-1:0] x1;
        logic [COORD_BITS-1:0] y1;
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
        logic                  sx_up;
        logic                  sy_up;
    } entry_t;

    entry_t                       ent;
    logic                         active_reg;
    logic                         active_next;
    logic [COORD_BITS-1:0]        cx_reg;
    logic [COORD_BITS-1:0]        cx_next;
    logic [COORD_BITS-1:0]        cy_reg;
    logic [COORD_BITS-1:0]        cy_next;
    logic [COORD_BITS-1:0]        x1_reg;
    logic [COORD_BITS-1:0]        y1_reg;
    logic [COORD_BITS-1:0]        dx_reg;
    logic [COORD_BITS-1:0]        dy_reg;
    logic                         sx_up_reg;
    logic                         sy_up_reg;
    logic signed [ErrBits-1:0]    err_reg;
    logic signed [ErrBits-1:0]    err_next;
    logic signed [TwiceBits-1:0]  twice;
    logic signed [TwiceBits-1:0]  dx_s;
    logic signed [TwiceBits-1:0]  dy_s;
    logic signed [TwiceBits-1:0]  err_sum;
    logic                         step_x;
    logic                         step_y;
    logic                         last;
    blpg_pkg::pixel_t             pixel_reg;
    logic                         strobe_reg;

    assign ent = entry;
    assign pop = !active_reg && !empty;

    always_comb
    begin
        dx_s    = $signed({3'b000, dx_reg});
        dy_s    = $signed({3'b000, dy_reg});
        twice   = $signed({err_reg, 1'b0});
        step_x  = twice > -dy_s;
        step_y  = twice < dx_s;
        err_sum = TwiceBits'(err_reg);
        if (step_x)
        begin
            err_sum = err_sum - dy_s;
        end
        if (step_y)
        begin
            err_sum = err_sum + dx_s;
        end
        cx_next = cx_reg;
        if (step_x)
        begin
            cx_next = sx_up_reg ? cx_reg + 1'b1 : cx_reg - 1'b1;
        end
        cy_next = cy_reg;
        if (step_y)
        begin
            cy_next = sy_up_reg ? cy_reg + 1'b1 : cy_reg - 1'b1;
        end
        last = (cx_next == x1_reg) && (cy_next == y1_reg);
        priority if (pop)
        begin
            active_next = 1'b1;
            err_next    = ErrBits'($signed({2'b00, ent.dx}) - $signed({2'b00, ent.dy}));
        end
        else
        begin
            active_next = active_reg && !last;
            err_next    = ErrBits'(err_sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            strobe_reg <= active_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cx_reg    <= ent.x0;
            cy_reg    <= ent.y0;
            x1_reg    <= ent.x1;
            y1_reg    <= ent.y1;
            dx_reg    <= ent.dx;
            dy_reg    <= ent.dy;
            sx_up_reg <= ent.sx_up;
            sy_up_reg <= ent.sy_up;
            err_reg   <= err_next;
        end
        else if (active_reg)
        begin
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
            err_reg <= err_next;
        end
        if (active_reg)
        begin
            pixel_reg.pixel_x    <= blpg_pkg::coord_t'(cx_reg);
            pixel_reg.pixel_y    <= blpg_pkg::coord_t'(cy_reg);
            pixel_reg.last_pixel <= last;
        end
    end

    assign pixel        = pixel_reg;
    assign pixel_strobe = strobe_reg;

endmodule
